>>> hdl/world_to_screen_projection_macros.svh
`ifndef WORLD_TO_SCREEN_PROJECTION_MACROS_SVH
`define WORLD_TO_SCREEN_PROJECTION_MACROS_SVH

// check a same-cycle implication out of reset
`define WSP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// check an implication in the next cycle, out of reset
`define WSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// check at every edge, reset included
`define WSP_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) (expr)) \
        else $error("assertion failed");

`endif

>>> hdl/wsp_pkg.sv
package wsp_pkg;

    localparam int SCREEN_W   = 1280;
    localparam int SCREEN_H   = 720;
    localparam int CFG_W      = 64;
    localparam int IDX_W      = 3;
    localparam int QBITS      = 32;
    localparam int DIV_STAGES = QBITS + 1;

    localparam logic signed [31:0] HALF_W = 32'(SCREEN_W * 32768);
    localparam logic signed [31:0] HALF_H = 32'(SCREEN_H * 32768);

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef enum logic [IDX_W-1:0] {
        REG_X_ROWS01 = 3'd0,
        REG_X_ROW2_OFFSET = 3'd1,
        REG_Y_ROWS01 = 3'd2,
        REG_Y_ROW2_OFFSET = 3'd3,
        REG_Z_ROWS01 = 3'd4,
        REG_Z_ROW2_OFFSET = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic signed [31:0] world_z;
    } in_t;

    typedef struct packed {
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
        logic               depth_zero;
    } out_t;

    typedef struct packed {
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] tz;
    } tvec_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] num;
        logic [31:0] quo;
        logic        neg;
        logic        ovf;
    } div_lane_t;

    typedef struct packed {
        div_lane_t   lx;
        div_lane_t   ly;
        logic [31:0] den;
        logic        zero;
    } div_stage_t;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [31:0] r;
        begin
            if (v > 50'sd2147483647)
                r = S32_MAX;
            else if (v < -50'sd2147483648)
                r = S32_MIN;
            else
                r = v[31:0];
            return r;
        end
    endfunction

endpackage

>>> hdl/world_to_screen_projection.sv
// channel | dir | handshake           | payload
// in      | in  | in_valid/in_ready   | in_data (world_x, world_y, world_z)
// out     | out | out_valid/out_ready | out_data (screen_x, screen_y, depth_zero)
// cfg     | in  | cfg_we              | cfg_index, cfg_data
//
// One beat per cycle in and out while out_ready is high; the path runs through two transform stages,
// the 32-stage divider plus its setup stage, and three viewport stages.
// rst_n clears all valid bits and loads the identity transform.
// Every stage holds only while it is full and the one after it is stalled,
// so bubbles close up and input is taken while a result waits.
module world_to_screen_projection (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  wsp_pkg::in_t                  in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output wsp_pkg::out_t                 out_data,
    input  logic                          cfg_we,
    input  logic [wsp_pkg::IDX_W-1:0]     cfg_index,
    input  logic [wsp_pkg::CFG_W-1:0]     cfg_data
);
    import wsp_pkg::*;

    logic [CFG_W-1:0] x01_reg, x2t_reg, y01_reg, y2t_reg, z01_reg, z2t_reg;

    logic                v1_reg, v2_reg, vn_reg, vv_reg, vo_reg;
    logic                r1, r2, rn, rv, ro;
    logic signed [47:0]  p1_reg [9];
    logic signed [47:0]  p1_next [9];
    tvec_t               t2_reg, t2_next;
    logic                div_in_ready, div_out_valid;
    div_stage_t          div_out;
    logic signed [31:0]  nx_reg, nx_next;
    logic signed [32:0]  nyn_reg, nyn_next;
    logic                zn_reg, zv_reg;
    logic signed [47:0]  px_reg, py_reg, px_next, py_next;
    out_t                o_reg, o_next;

    function automatic logic signed [47:0] mulq(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        begin
            p = 64'(a) * 64'(b);
            return p[63:16];
        end
    endfunction

    function automatic logic signed [31:0] fin(input div_lane_t l);
        logic signed [31:0] r;
        begin
            if (!l.neg)
                r = (l.ovf || l.quo[31]) ? S32_MAX : $signed(l.quo);
            else
                r = (l.ovf || l.quo > 32'h8000_0000) ? S32_MIN : $signed(32'(-l.quo));
            return r;
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x01_reg <= 64'h0000_0000_0001_0000;
            x2t_reg <= '0;
            y01_reg <= 64'h0001_0000_0000_0000;
            y2t_reg <= '0;
            z01_reg <= '0;
            z2t_reg <= 64'h0000_0000_0001_0000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_X_ROWS01:      x01_reg <= cfg_data;
                REG_X_ROW2_OFFSET: x2t_reg <= cfg_data;
                REG_Y_ROWS01:      y01_reg <= cfg_data;
                REG_Y_ROW2_OFFSET: y2t_reg <= cfg_data;
                REG_Z_ROWS01:      z01_reg <= cfg_data;
                REG_Z_ROW2_OFFSET: z2t_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign ro = !vo_reg || out_ready;
    assign rv = !vv_reg || ro;
    assign rn = !vn_reg || rv;
    assign r2 = !v2_reg || div_in_ready;
    assign r1 = !v1_reg || r2;
    assign in_ready = r1;

    always_comb
    begin
        p1_next[0] = mulq($signed(x01_reg[31:0]),  in_data.world_x);
        p1_next[1] = mulq($signed(x01_reg[63:32]), in_data.world_y);
        p1_next[2] = mulq($signed(x2t_reg[31:0]),  in_data.world_z);
        p1_next[3] = mulq($signed(y01_reg[31:0]),  in_data.world_x);
        p1_next[4] = mulq($signed(y01_reg[63:32]), in_data.world_y);
        p1_next[5] = mulq($signed(y2t_reg[31:0]),  in_data.world_z);
        p1_next[6] = mulq($signed(z01_reg[31:0]),  in_data.world_x);
        p1_next[7] = mulq($signed(z01_reg[63:32]), in_data.world_y);
        p1_next[8] = mulq($signed(z2t_reg[31:0]),  in_data.world_z);
    end

    always_comb
    begin
        t2_next.tx = sat32(50'(p1_reg[0]) + 50'(p1_reg[1]) + 50'(p1_reg[2])
                           + 50'($signed(x2t_reg[63:32])));
        t2_next.ty = sat32(50'(p1_reg[3]) + 50'(p1_reg[4]) + 50'(p1_reg[5])
                           + 50'($signed(y2t_reg[63:32])));
        t2_next.tz = sat32(50'(p1_reg[6]) + 50'(p1_reg[7]) + 50'(p1_reg[8])
                           + 50'($signed(z2t_reg[63:32])));
    end

    wsp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2_reg),
        .in_ready  (div_in_ready),
        .in_data   (t2_reg),
        .out_valid (div_out_valid),
        .out_ready (rn),
        .out_data  (div_out)
    );

    always_comb
    begin
        nx_next  = fin(div_out.lx);
        nyn_next = -33'(fin(div_out.ly));
    end

    always_comb
    begin
        logic signed [63:0] pxw;
        logic signed [63:0] pyw;
        pxw = 64'(HALF_W) * 64'(nx_reg);
        pyw = 64'(HALF_H) * 64'(nyn_reg);
        px_next = pxw[63:16];
        py_next = pyw[63:16];
    end

    always_comb
    begin
        if (zv_reg)
        begin
            o_next.screen_x   = '0;
            o_next.screen_y   = '0;
            o_next.depth_zero = 1'b1;
        end
        else
        begin
            o_next.screen_x   = sat32(50'(px_reg) + 50'(HALF_W));
            o_next.screen_y   = sat32(50'(py_reg) + 50'(HALF_H));
            o_next.depth_zero = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vn_reg <= 1'b0;
            vv_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (r1)
                v1_reg <= in_valid;
            if (r2)
                v2_reg <= v1_reg;
            if (rn)
                vn_reg <= div_out_valid;
            if (rv)
                vv_reg <= vn_reg;
            if (ro)
                vo_reg <= vv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1)
            p1_reg <= p1_next;
        if (r2)
            t2_reg <= t2_next;
        if (rn)
        begin
            nx_reg  <= nx_next;
            nyn_reg <= nyn_next;
            zn_reg  <= div_out.zero;
        end
        if (rv)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
            zv_reg <= zn_reg;
        end
        if (ro)
            o_reg <= o_next;
    end

    assign out_valid = vo_reg;
    assign out_data  = o_reg;

endmodule

>>> hdl/wsp_div.sv
module wsp_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  wsp_pkg::tvec_t     in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output wsp_pkg::div_stage_t out_data
);
    import wsp_pkg::*;

    logic        [DIV_STAGES-1:0] vld_reg;
    div_stage_t                   stg_reg [DIV_STAGES];
    logic        [DIV_STAGES-1:0] rdy;
    div_stage_t                   setup;
    logic        [31:0]           ax;
    logic        [31:0]           ay;
    logic        [31:0]           az;

    function automatic div_lane_t step(input div_lane_t l, input logic [31:0] d);
        div_lane_t   o;
        logic [32:0] r2;
        logic [32:0] df;
        begin
            o = l;
            r2 = {l.rem, l.num[31]};
            df = r2 - {1'b0, d};
            o.num = {l.num[30:0], 1'b0};
            if (!df[32])
            begin
                o.rem = df[31:0];
                o.quo = {l.quo[30:0], 1'b1};
            end
            else
            begin
                o.rem = r2[31:0];
                o.quo = {l.quo[30:0], 1'b0};
            end
            return o;
        end
    endfunction

    always_comb
    begin
        ax = in_data.tx[31] ? 32'(-in_data.tx) : 32'(in_data.tx);
        ay = in_data.ty[31] ? 32'(-in_data.ty) : 32'(in_data.ty);
        az = in_data.tz[31] ? 32'(-in_data.tz) : 32'(in_data.tz);
        setup.den = az;
        setup.zero = (in_data.tz == 32'sd0);
        setup.lx.rem = {16'd0, ax[31:16]};
        setup.lx.num = {ax[15:0], 16'd0};
        setup.lx.quo = '0;
        setup.lx.neg = in_data.tx[31] ^ in_data.tz[31];
        setup.lx.ovf = ({16'd0, ax[31:16]} >= az);
        setup.ly.rem = {16'd0, ay[31:16]};
        setup.ly.num = {ay[15:0], 16'd0};
        setup.ly.quo = '0;
        setup.ly.neg = in_data.ty[31] ^ in_data.tz[31];
        setup.ly.ovf = ({16'd0, ay[31:16]} >= az);
    end

    always_comb
    begin
        rdy[DIV_STAGES-1] = !vld_reg[DIV_STAGES-1] || out_ready;
        for (int i = DIV_STAGES - 2; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
                vld_reg[0] <= in_valid;
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                if (rdy[i])
                    vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
            stg_reg[0] <= setup;
        for (int i = 1; i < DIV_STAGES; i++)
        begin
            if (rdy[i])
            begin
                stg_reg[i].lx   <= step(stg_reg[i-1].lx, stg_reg[i-1].den);
                stg_reg[i].ly   <= step(stg_reg[i-1].ly, stg_reg[i-1].den);
                stg_reg[i].den  <= stg_reg[i-1].den;
                stg_reg[i].zero <= stg_reg[i-1].zero;
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[DIV_STAGES-1];
    assign out_data  = stg_reg[DIV_STAGES-1];

endmodule

>>> hdl/wsp_checker.sv
`include "world_to_screen_projection_macros.svh"

module wsp_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input wsp_pkg::out_t out_data
);
    import wsp_pkg::*;

    `WSP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
    `WSP_ASSERT_NOW(a_zero_depth, out_valid && out_data.depth_zero, out_data.screen_x == 32'sd0 && out_data.screen_y == 32'sd0)
    `WSP_ASSERT_NOW(a_full_only, !in_ready, out_valid && !out_ready)
    `WSP_ASSERT_ALWAYS(a_reset_idle, rst_n || (!out_valid && in_ready))

endmodule

bind world_to_screen_projection wsp_checker u_wsp_checker (.*);

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import wsp_pkg::*;

    localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;
    localparam int NUM_REGS = 6;
    localparam int PIPE_DEPTH = 38;

    class projection_scoreboard;
        logic [CFG_W-1:0] coef[NUM_REGS];
        out_t pending_points[$];
        int errors;

        function new();
            coef[REG_X_ROWS01] = 64'h1_0000;
            coef[REG_X_ROW2_OFFSET] = 64'h0;
            coef[REG_Y_ROWS01] = 64'h1_0000 << 32;
            coef[REG_Y_ROW2_OFFSET] = 64'h0;
            coef[REG_Z_ROWS01] = 64'h0;
            coef[REG_Z_ROW2_OFFSET] = 64'h1_0000;
            errors = 0;
        endfunction

        function void load_coef(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            if (idx < NUM_REGS)
                coef[idx] = value;
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        function longint half_to_q(logic [31:0] h);
            return longint'($signed(h));
        endfunction

        function longint transform_axis(int axis, longint x, longint y, longint z);
            logic [63:0] a;
            logic [63:0] b;
            longint s;
            a = coef[2 * axis];
            b = coef[2 * axis + 1];
            s = ((half_to_q(a[31:0]) * x) >>> 16) + ((half_to_q(a[63:32]) * y) >>> 16)
                + ((half_to_q(b[31:0]) * z) >>> 16) + half_to_q(b[63:32]);
            return clamp32(s);
        endfunction

        function longint to_pixels(longint half, longint ndc);
            return clamp32(((half * ndc) >>> 16) + half);
        endfunction

        function out_t project(in_t p);
            out_t r;
            longint x, y, z, tx, ty, tz, nx, ny, hw, hh;
            x = longint'(p.world_x);
            y = longint'(p.world_y);
            z = longint'(p.world_z);
            tx = transform_axis(0, x, y, z);
            ty = transform_axis(1, x, y, z);
            tz = transform_axis(2, x, y, z);
            hw = longint'(SCREEN_W) * 32768;
            hh = longint'(SCREEN_H) * 32768;
            r = '0;
            if (tz == 0)
            begin
                r.depth_zero = 1'b1;
                return r;
            end
            nx = clamp32((tx * 65536) / tz);
            ny = clamp32((ty * 65536) / tz);
            r.screen_x = 32'(to_pixels(hw, nx));
            r.screen_y = 32'(to_pixels(hh, -ny));
            return r;
        endfunction

        function void note_point(in_t p);
            pending_points.push_back(project(p));
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        task check_result(out_t got);
            out_t want;
            if (pending_points.size() == 0)
            begin
                report($sformatf("unexpected result %h", got));
                return;
            end
            want = pending_points.pop_front();
            if (got.screen_x !== want.screen_x)
                report($sformatf("screen_x got %h want %h", got.screen_x, want.screen_x));
            if (got.screen_y !== want.screen_y)
                report($sformatf("screen_y got %h want %h", got.screen_y, want.screen_y));
            if (got.depth_zero !== want.depth_zero)
                report($sformatf("depth_zero got %b want %b", got.depth_zero, want.depth_zero));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b1;
    logic in_valid = 1'b0;
    logic in_ready;
    in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;
    logic cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    projection_scoreboard sb = new();
    bit long_hold_req = 1'b0;

    world_to_screen_projection i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    // receiver: stall pattern is drawn at random from four modes, long hold on request
    initial
    begin
        int cyc;
        int mode;
        int hold_left;
        cyc = 0;
        mode = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_result(out_data);
            cyc++;
            if (cyc % 64 == 0)
                mode = $urandom_range(0, 3);
            if (long_hold_req && hold_left == 0)
            begin
                hold_left = 300;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= $urandom_range(0, 1);
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= (cyc % 7 < 3);
                endcase
            end
        end
    end

    task send_point(in_t p);
        in_valid <= 1'b1;
        in_data <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_point(p);
    endtask

    task write_coef(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        sb.load_coef(idx, value);
    endtask

    task drain();
        while (sb.pending_points.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 4) @(posedge clk);
    endtask

    function logic [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sh8000_0000;
            3: return 32'($urandom_range(0, 32'h0080_0000)) - 32'h0040_0000;
            4: return 32'($urandom_range(0, 32'h4000_0000)) - 32'h2000_0000;
            default: return 32'($urandom_range(0, 64)) - 32;
        endcase
    endfunction

    function logic [31:0] pick_coef(bit tame);
        if (tame)
            return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sh8000_0000;
            default: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
        endcase
    endfunction

    task load_matrix(int style);
        logic [31:0] lo, hi;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            case (style)
                0:
                begin
                    lo = 32'sh7FFF_FFFF;
                    hi = 32'sh7FFF_FFFF;
                end
                1:
                begin
                    lo = 32'sh8000_0000;
                    hi = 32'sh8000_0000;
                end
                2:
                begin
                    lo = 32'h0;
                    hi = 32'h0;
                end
                3:
                begin
                    lo = pick_coef(1'b0);
                    hi = pick_coef(1'b0);
                end
                default:
                begin
                    lo = pick_coef(1'b1);
                    hi = pick_coef(1'b1);
                end
            endcase
            write_coef(i[IDX_W-1:0], {hi, lo});
        end
        write_coef(REG_SPARE_A, {$urandom, $urandom});
        write_coef(REG_SPARE_B, {$urandom, $urandom});
        cfg_we <= 1'b0;
    endtask

    task random_points(int count, bit no_gaps);
        in_t p;
        int left;
        int burst;
        left = count;
        while (left > 0)
        begin
            burst = no_gaps ? left : $urandom_range(1, 20);
            if (burst > left)
                burst = left;
            for (int i = 0; i < burst; i++)
            begin
                p.world_x = pick_coord();
                p.world_y = pick_coord();
                p.world_z = pick_coord();
                send_point(p);
            end
            left -= burst;
            in_valid <= 1'b0;
            if (!no_gaps)
                repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    initial
    begin
        in_t p;
        logic [31:0] corner[6];
        corner = '{32'h0, 32'h1_0000, 32'hFFFF_0000,
                   32'sh7FFF_FFFF, 32'sh8000_0000, 32'h1};
        #1;
        rst_n <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 6; i++)
        begin
            p.world_x = corner[i];
            p.world_y = corner[(i + 2) % 6];
            p.world_z = corner[(i + 3) % 6];
            send_point(p);
        end
        p = '{32'h0, 32'h0, 32'h0};
        send_point(p);
        p = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
        send_point(p);
        p = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
        send_point(p);
        p = '{32'h0280_0000, 32'hFE80_0000, 32'h0000_0001};
        send_point(p);
        p = '{32'h0005_0000, 32'h0003_0000, 32'hFFFE_0000};
        send_point(p);
        random_points(100, 1'b0);
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            load_matrix(phase < 3 ? phase : (phase == 3 ? 3 : 4));
            if (phase == 5)
            begin
                long_hold_req = 1'b1;
                random_points(100, 1'b1);
            end
            else
                random_points(100, 1'b0);
            drain();
        end

        if (sb.pending_points.size() != 0)
            sb.report("results missing at end");
        if (sb.errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule

>>> world_to_screen_projection.f
+incdir+hdl
hdl/wsp_pkg.sv
hdl/wsp_div.sv
hdl/world_to_screen_projection.sv
hdl/wsp_checker.sv
sim/testbench.sv
